// ----- rtl/msp_pkg.sv -----
// Shared types, constants and helpers for the multi-stack shared pool.
`default_nettype none

package msp_pkg;

  localparam int NUM_STACKS = 4;
  localparam int POOL_SLOTS = 256;
  localparam int SIDX_W     = 2;
  localparam int DATA_W     = 32;
  localparam int SLOT_W     = $clog2(POOL_SLOTS);
  localparam int PTR_W      = $clog2(POOL_SLOTS + 1);

  // stream packing: stack_index then push_value, padded to whole bytes
  localparam int IN_TDATA_W  = ((SIDX_W + DATA_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DATA_W + 7) / 8) * 8;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [SIDX_W-1:0] sidx_t;
  typedef logic [DATA_W-1:0] data_t;

  // null pointer: one past the last slot
  localparam ptr_t PTR_NULL = PTR_W'(POOL_SLOTS);

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic  we;
    slot_t waddr;
    ptr_t  wdata;
    logic  re;
    slot_t raddr;
  } link_req_t;

  typedef struct packed {
    logic  we;
    slot_t waddr;
    data_t wdata;
    logic  re;
    slot_t raddr;
  } data_req_t;

  function automatic logic is_null(ptr_t p);
    return p >= PTR_NULL;
  endfunction

  function automatic slot_t to_slot(ptr_t p);
    return p[SLOT_W-1:0];
  endfunction

  function automatic ptr_t to_ptr(slot_t s);
    return PTR_W'(s);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/msp_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
`default_nettype none

module msp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/msp_link.sv -----
// Link store: link RAM plus per-slot valid bits giving the reset chain.
`default_nettype none

module msp_link
  import msp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire link_req_t req,
  output ptr_t           rdata
);

  logic [POOL_SLOTS-1:0] vld_r;
  logic                  vld_q_r;
  slot_t                 addr_q_r;
  ptr_t                  ram_q;

  msp_ram #(
    .WIDTH (PTR_W),
    .DEPTH (POOL_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (req.we),
    .waddr (req.waddr),
    .wdata (req.wdata),
    .re    (req.re),
    .raddr (req.raddr),
    .rdata (ram_q)
  );

  // a slot never written still holds its reset link: slot + 1 (last gives null)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.we) begin
      vld_r[req.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      vld_q_r  <= vld_r[req.raddr];
      addr_q_r <= req.raddr;
    end
  end

  assign rdata = vld_q_r ? ram_q : to_ptr(addr_q_r) + PTR_W'(1);

endmodule

`default_nettype wire

// ----- rtl/msp_alloc.sv -----
// Stack tops, free list head and prefetched next links; executes one beat.
`default_nettype none

module msp_alloc
  import msp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  exec,
  input  wire cmd_t  cmd,
  input  wire sidx_t sidx,
  input  wire data_t push_value,
  input  wire ptr_t  link_rdata,
  output link_req_t  link_req,
  output data_req_t  data_req,
  output status_t    status,
  output logic       pop_ok
);

  ptr_t  free_head_r, free_head_nxt;
  ptr_t  free_next_r, free_next_nxt;
  ptr_t  top_r       [NUM_STACKS];
  ptr_t  top_nxt     [NUM_STACKS];
  ptr_t  top_next_r  [NUM_STACKS];
  ptr_t  top_next_nxt[NUM_STACKS];
  logic  pend_free_r, pend_free_nxt;
  logic  pend_top_r,  pend_top_nxt;
  sidx_t pend_sidx_r, pend_sidx_nxt;

  ptr_t  eff_free_next;
  ptr_t  eff_top_next[NUM_STACKS];
  ptr_t  cur_top;
  ptr_t  cur_top_next;
  logic  in_range;
  logic  push_can;
  logic  pop_can;

  // link read issued last cycle lands now; forward it ahead of the register
  always_comb begin
    eff_free_next = pend_free_r ? link_rdata : free_next_r;
    for (int i = 0; i < NUM_STACKS; i++) begin
      eff_top_next[i] = (pend_top_r && pend_sidx_r == SIDX_W'(i)) ? link_rdata
                                                                  : top_next_r[i];
    end
  end

  assign in_range     = int'(sidx) < NUM_STACKS;
  assign cur_top      = top_r[sidx];
  assign cur_top_next = eff_top_next[sidx];
  assign push_can     = (cmd == CMD_PUSH) && in_range && !is_null(free_head_r);
  assign pop_can      = (cmd == CMD_POP) && in_range && !is_null(cur_top);
  assign pop_ok       = pop_can;

  always_comb begin
    if (cmd == CMD_PUSH) begin
      status = push_can ? ST_DONE : ST_FULL;
    end else begin
      status = pop_can ? ST_DONE : ST_EMPTY;
    end
  end

  always_comb begin
    free_head_nxt = free_head_r;
    free_next_nxt = eff_free_next;
    for (int i = 0; i < NUM_STACKS; i++) begin
      top_nxt[i]      = top_r[i];
      top_next_nxt[i] = eff_top_next[i];
    end
    pend_free_nxt = 1'b0;
    pend_top_nxt  = 1'b0;
    pend_sidx_nxt = pend_sidx_r;

    link_req       = '0;
    link_req.waddr = to_slot(free_head_r);
    link_req.raddr = to_slot(eff_free_next);
    data_req       = '0;
    data_req.waddr = to_slot(free_head_r);
    data_req.wdata = push_value;
    data_req.raddr = to_slot(cur_top);

    if (exec && push_can) begin
      // head of free list becomes the new top, linked to the old top
      data_req.we        = 1'b1;
      link_req.we        = 1'b1;
      link_req.wdata     = cur_top;
      top_nxt[sidx]      = free_head_r;
      top_next_nxt[sidx] = cur_top;
      free_head_nxt      = eff_free_next;
      if (is_null(eff_free_next)) begin
        free_next_nxt = PTR_NULL;
      end else begin
        link_req.re   = 1'b1;
        pend_free_nxt = 1'b1;
      end
    end else if (exec && pop_can) begin
      // top slot goes back to the head of the free list
      data_req.re        = 1'b1;
      link_req.we        = 1'b1;
      link_req.waddr     = to_slot(cur_top);
      link_req.wdata     = free_head_r;
      free_head_nxt      = cur_top;
      free_next_nxt      = free_head_r;
      top_nxt[sidx]      = cur_top_next;
      link_req.raddr     = to_slot(cur_top_next);
      if (is_null(cur_top_next)) begin
        top_next_nxt[sidx] = PTR_NULL;
      end else begin
        link_req.re   = 1'b1;
        pend_top_nxt  = 1'b1;
        pend_sidx_nxt = sidx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r <= '0;
      free_next_r <= PTR_W'(1);
      for (int i = 0; i < NUM_STACKS; i++) begin
        top_r[i]      <= PTR_NULL;
        top_next_r[i] <= PTR_NULL;
      end
      pend_free_r <= 1'b0;
      pend_top_r  <= 1'b0;
      pend_sidx_r <= '0;
    end else begin
      free_head_r <= free_head_nxt;
      free_next_r <= free_next_nxt;
      for (int i = 0; i < NUM_STACKS; i++) begin
        top_r[i]      <= top_nxt[i];
        top_next_r[i] <= top_next_nxt[i];
      end
      pend_free_r <= pend_free_nxt;
      pend_top_r  <= pend_top_nxt;
      pend_sidx_r <= pend_sidx_nxt;
    end
  end

`ifndef SYNTHESIS
  a_one_link_read: assert property (@(posedge clk) disable iff (!rst_n)
    !(pend_free_r && pend_top_r))
    else $error("two link reads outstanding at once");

  a_push_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && push_can) |=> free_head_r == $past(eff_free_next))
    else $error("push did not advance the free head");

  a_pop_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && pop_can) |=> free_head_r == $past(cur_top))
    else $error("pop did not return its slot to the free list");

  for (genvar g = 0; g < NUM_STACKS; g++) begin : g_chk
    a_head_not_top: assert property (@(posedge clk) disable iff (!rst_n)
      !is_null(free_head_r) |-> free_head_r != top_r[g])
      else $error("free head is also a stack top");
  end
`endif

endmodule

`default_nettype wire

// ----- rtl/multi_stack_shared_pool_unit.sv -----
// Top level: several LIFO stacks sharing one slot pool with a linked free list.
//
// Input beats (in_*) carry a push or a pop aimed at one stack; each beat gives
// exactly one result beat (out_*) carrying a status code and the popped value.
//   in_tuser  : cmd (0 push, 1 pop)
//   in_tdata  : stack_index, push_value
//   out_tuser : status (0 done, 1 push refused pool full, 2 pop refused empty)
//   out_tdata : pop_value, zero unless a pop succeeded
// A beat taken into the input register passes once through the allocator into
// the output register, which holds its result on out_*. Throughput: one beat
// per cycle while out_tready stays high, pushes and pops in any mix. The
// limit is the single link-store read per beat; the next link of the new free
// head or new top is prefetched and forwarded to the following beat.
// Reset (rst_n low, synchronous): every stack empty, free list runs through
// all slots in order. The link store's reset chain comes from per-slot valid
// bits, so there is no clearing pass and a beat may be taken straight away.
// When out_tready is low the result holds in the output register; one further
// beat still enters the input register, then in_tready drops.
`default_nettype none

module multi_stack_shared_pool_unit
  import msp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [1:0] stack_index, [33:2] push_value
  input  wire logic [0:0]             in_tuser,   // [0] cmd
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // [31:0] pop_value
  output logic [1:0]                  out_tuser   // [1:0] status
);

  // input register
  logic      in_v_r;
  cmd_t      cmd_r;
  sidx_t     sidx_r;
  data_t     val_r;

  // output register
  logic      out_v_r;
  status_t   status_r;
  logic      pop_ok_r;

  logic      exec;
  status_t   status;
  logic      pop_ok;
  link_req_t link_req;
  data_req_t data_req;
  ptr_t      link_rdata;
  data_t     data_q;

  // beat in the input register moves on whenever the output slot frees up
  assign exec      = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || exec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_v_r <= 1'b1;
    end else if (exec) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r  <= cmd_t'(in_tuser[0]);
      sidx_r <= in_tdata[SIDX_W-1:0];
      val_r  <= in_tdata[SIDX_W+DATA_W-1:SIDX_W];
    end
  end

  msp_alloc u_alloc (
    .clk        (clk),
    .rst_n      (rst_n),
    .exec       (exec),
    .cmd        (cmd_r),
    .sidx       (sidx_r),
    .push_value (val_r),
    .link_rdata (link_rdata),
    .link_req   (link_req),
    .data_req   (data_req),
    .status     (status),
    .pop_ok     (pop_ok)
  );

  msp_link u_link (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (link_req),
    .rdata (link_rdata)
  );

  // data store: read only on a successful pop, so its output holds under stall
  msp_ram #(
    .WIDTH (DATA_W),
    .DEPTH (POOL_SLOTS)
  ) u_data (
    .clk   (clk),
    .we    (data_req.we),
    .waddr (data_req.waddr),
    .wdata (data_req.wdata),
    .re    (data_req.re),
    .raddr (data_req.raddr),
    .rdata (data_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (exec) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      status_r <= status;
      pop_ok_r <= pop_ok;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = status_r;
  assign out_tdata  = pop_ok_r ? OUT_TDATA_W'(data_q) : '0;

endmodule

`default_nettype wire

// ----- test/msp_stack_checker.sv -----
// Checker for the shared-pool stacks: watches both streams, tracks the pool and compares results.
`timescale 1ns / 1ps

module msp_stack_checker
  import msp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  input  wire logic                   in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [1:0] stack_index, [33:2] push_value
  input  wire logic [0:0]             in_tuser,   // [0] cmd
  input  wire logic                   out_tvalid,
  input  wire logic                   out_tready,
  input  wire logic [OUT_TDATA_W-1:0] out_tdata,  // [31:0] pop_value
  input  wire logic [1:0]             out_tuser,  // [1:0] status
  output int                          fail_count,
  output int                          outstanding
);

  typedef struct {
    status_t status;
    data_t   value;
  } stack_result_t;

  stack_result_t pending_results[$];

  // own copy of the pool: links, payloads, stack tops, free-list head
  ptr_t  link_mem [POOL_SLOTS];
  data_t data_mem [POOL_SLOTS];
  ptr_t  top_ptr  [NUM_STACKS];
  ptr_t  free_ptr;

  task automatic pool_reset();
    for (int i = 0; i < POOL_SLOTS; i++) begin
      link_mem[i] = ptr_t'(i + 1);  // last slot lands on null
      data_mem[i] = '0;
    end
    for (int k = 0; k < NUM_STACKS; k++) top_ptr[k] = PTR_NULL;
    free_ptr = '0;
    pending_results.delete();
  endtask

  // Applies one push or pop to the pool copy and returns the result it gives.
  function automatic stack_result_t pool_apply(cmd_t op, sidx_t sidx, data_t value);
    stack_result_t res;
    ptr_t          slot;
    res.status = ST_DONE;
    res.value  = '0;
    if (op == CMD_PUSH) begin
      slot = free_ptr;
      if (int'(sidx) >= NUM_STACKS || slot >= PTR_NULL) begin
        res.status = ST_FULL;
      end else begin
        free_ptr                     = link_mem[slot[SLOT_W-1:0]];
        data_mem[slot[SLOT_W-1:0]]   = value;
        link_mem[slot[SLOT_W-1:0]]   = top_ptr[sidx];
        top_ptr[sidx]                = slot;
      end
    end else begin
      if (int'(sidx) >= NUM_STACKS) begin
        res.status = ST_EMPTY;
      end else begin
        slot = top_ptr[sidx];
        if (slot >= PTR_NULL) begin
          res.status = ST_EMPTY;
        end else begin
          top_ptr[sidx]              = link_mem[slot[SLOT_W-1:0]];
          link_mem[slot[SLOT_W-1:0]] = free_ptr;
          free_ptr                   = slot;
          res.value                  = data_mem[slot[SLOT_W-1:0]];
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    stack_result_t want;
    if (!rst_n) begin
      pool_reset();
    end else begin
      // results first: a beat taken at this edge cannot answer at the same edge
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          $error("result beat with nothing pending: status %0d, pop_value %0h",
                 out_tuser, out_tdata[DATA_W-1:0]);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_tuser !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, out_tuser);
            fail_count++;
          end
          if (out_tdata[DATA_W-1:0] !== want.value) begin
            $error("pop_value mismatch: expected %0h, actual %0h",
                   want.value, out_tdata[DATA_W-1:0]);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        pending_results.push_back(pool_apply(cmd_t'(in_tuser[0]),
                                             sidx_t'(in_tdata[SIDX_W-1:0]),
                                             data_t'(in_tdata[SIDX_W +: DATA_W])));
      end
    end
    outstanding = pending_results.size();
  end

endmodule

// ----- test/tb_top.sv -----
// Testbench top for the shared-pool stacks: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import msp_pkg::*;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // [1:0] stack_index, [33:2] push_value
  logic [0:0]             in_tuser   = '0;   // [0] cmd
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // [31:0] pop_value
  logic [1:0]             out_tuser;         // [1:0] status

  int fail_count;
  int outstanding;

  // idle odds in percent, changed per phase
  int gap_pct   = 26;   // sender holds tvalid low
  int stall_pct = 86;   // receiver holds tready low

  always #5 clk = ~clk;

  multi_stack_shared_pool_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  msp_stack_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Receiver back-pressure: a fresh draw every cycle, one update per edge.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Offers one beat, with random idle cycles ahead of it. Handshake is
  // looked at on the falling edge, where everything is settled; a beat seen
  // with tready high there is taken at the following rising edge.
  task automatic send_beat(cmd_t op, sidx_t sidx, data_t value);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_TDATA_W'({value, sidx});
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
  endtask

  // Random beats with a push bias: a high bias fills the pool past full,
  // a low one drains every stack and keeps hitting empty ones.
  task automatic run_segment(int beats, int push_pct);
    data_t value;
    for (int n = 0; n < beats; n++) begin
      if ($urandom_range(7) == 0) begin
        // sprinkle the corner values among the random ones
        case ($urandom_range(3))
          0:       value = 32'h8000_0000;
          1:       value = 32'h7FFF_FFFF;
          2:       value = '0;
          default: value = '1;
        endcase
      end else begin
        value = $urandom();
      end
      send_beat(($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP,
                sidx_t'($urandom_range(NUM_STACKS - 1)), value);
    end
  endtask

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed: sender idles lightly, receiver stalls hard ---
    // every stack starts empty; payload on a pop must be ignored
    send_beat(CMD_POP,  2'd0, 32'hFFFF_FFFF);
    send_beat(CMD_POP,  2'd1, 32'h0000_0000);
    send_beat(CMD_POP,  2'd2, 32'hFFFF_FFFF);
    send_beat(CMD_POP,  2'd3, 32'h1234_5678);
    // extremes of the payload spread over all stacks
    send_beat(CMD_PUSH, 2'd0, 32'h8000_0000);
    send_beat(CMD_PUSH, 2'd1, 32'h7FFF_FFFF);
    send_beat(CMD_PUSH, 2'd2, 32'h0000_0000);
    send_beat(CMD_PUSH, 2'd3, 32'hFFFF_FFFF);
    send_beat(CMD_PUSH, 2'd0, 32'h5555_5555);
    send_beat(CMD_PUSH, 2'd0, 32'hAAAA_AAAA);
    // LIFO order on stack 0, then one pop too many
    send_beat(CMD_POP,  2'd0, 32'hFFFF_FFFF);
    send_beat(CMD_POP,  2'd0, 32'h0000_0000);
    send_beat(CMD_POP,  2'd0, 32'hFFFF_FFFF);
    send_beat(CMD_POP,  2'd0, 32'h0000_0000);
    send_beat(CMD_POP,  2'd1, 32'h0000_0000);
    send_beat(CMD_POP,  2'd2, 32'h0000_0000);
    send_beat(CMD_POP,  2'd3, 32'h0000_0000);
    send_beat(CMD_POP,  2'd3, 32'h0000_0000);
    // freed slots come straight back: push then pop back to back
    send_beat(CMD_PUSH, 2'd1, 32'hDEAD_BEEF);
    send_beat(CMD_POP,  2'd1, 32'h0000_0000);
    send_beat(CMD_PUSH, 2'd2, 32'h0F0F_0F0F);
    send_beat(CMD_PUSH, 2'd2, 32'hF0F0_F0F0);
    send_beat(CMD_POP,  2'd2, 32'h0000_0000);
    send_beat(CMD_POP,  2'd2, 32'h0000_0000);

    // --- random, phase one: fill beyond full, then a mixed run ---
    run_segment(300, 97);
    run_segment(50, 50);

    // --- phase two: sender idles hard, receiver lightly; drain ---
    gap_pct   = 86;
    stall_pct = 26;
    run_segment(300, 5);
    run_segment(50, 50);

    // --- phase three: no idling at all, fill to full again, partial drain ---
    gap_pct   = 0;
    stall_pct = 0;
    run_segment(300, 97);
    run_segment(50, 5);

    in_tvalid <= 1'b0;

    // let the last results drain, then wait out any strays
    do @(negedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
